// ===== hdl/bmte_pkg.sv =====
// shared types and constants for the bitmap to ansi text encoder
package bmte_pkg;

    localparam int MAX_LINE_PIXELS = 4096;
    localparam int RUN_W           = $clog2(MAX_LINE_PIXELS + 1);
    localparam int RUN_DIGITS      = 4;
    localparam int CFG_INDEX_W     = 1;
    localparam int CFG_DATA_W      = 8;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_THRESH = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MARK   = 1'd1;

    localparam logic [3:0] THRESH_RESET = 4'd5;
    localparam logic [3:0] THRESH_CAP   = 4'd7;
    localparam logic [7:0] MARK_RESET   = 8'd42;

    localparam logic [7:0] CH_ESC   = 8'd27;
    localparam logic [7:0] CH_LBR   = 8'd91;
    localparam logic [7:0] CH_H     = 8'd72;
    localparam logic [7:0] CH_J     = 8'd74;
    localparam logic [7:0] CH_C     = 8'd67;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_ZERO  = 8'd48;

    typedef struct packed {
        logic pixel;
        logic first_of_page;
        logic last_of_line;
        logic last_of_page;
    } in_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_of_run;
    } out_t;

    // one classified request for the character sequencer
    typedef struct packed {
        logic                      hdr;
        logic                      px;
        logic                      esc;
        logic [RUN_DIGITS-1:0][3:0] run;
        logic [1:0]                top_digit;
        logic                      eol;
        logic                      eop;
    } cmd_t;

endpackage

// ===== hdl/bmte_front.sv =====
// front end: counts blank runs in decimal and classifies each request
module bmte_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  bmte_pkg::in_t    in_data,
    input  logic             queue_full,
    input  logic [3:0]       thr,
    output logic             in_stall,
    output logic             push,
    output bmte_pkg::cmd_t   cmd
);
    import bmte_pkg::*;

    logic [RUN_W-1:0]            run_bin_reg, run_bin_next;
    logic [RUN_DIGITS-1:0][3:0]  run_bcd_reg, run_bcd_next;
    logic [RUN_W-1:0]            base_bin;
    logic [RUN_DIGITS-1:0][3:0]  base_bcd;
    logic [RUN_DIGITS-1:0][3:0]  inc_bcd;
    logic                        carry;
    logic [3:0]                  thr_eff;
    logic                        accept;
    logic                        eol_any;

    assign in_stall = queue_full;
    assign accept   = in_valid && !in_stall;
    assign eol_any  = in_data.last_of_line || in_data.last_of_page;
    assign thr_eff  = (thr > THRESH_CAP) ? THRESH_CAP : thr;

    assign base_bin = in_data.first_of_page ? '0 : run_bin_reg;
    assign base_bcd = in_data.first_of_page ? '0 : run_bcd_reg;

    // decimal increment, one carry per digit
    always_comb
    begin
        carry = 1'b1;
        for (int i = 0; i < RUN_DIGITS; i++)
        begin
            if (carry && base_bcd[i] == 4'd9)
            begin
                inc_bcd[i] = 4'd0;
            end
            else
            begin
                inc_bcd[i] = base_bcd[i] + {3'd0, carry};
                carry      = 1'b0;
            end
        end
    end

    always_comb
    begin
        run_bin_next = base_bin;
        run_bcd_next = base_bcd;
        if (in_data.pixel || eol_any)
        begin
            run_bin_next = '0;
            run_bcd_next = '0;
        end
        else if (base_bin != RUN_W'(MAX_LINE_PIXELS))
        begin
            run_bin_next = base_bin + RUN_W'(1);
            run_bcd_next = inc_bcd;
        end
    end

    always_comb
    begin
        cmd.hdr = in_data.first_of_page;
        cmd.px  = in_data.pixel;
        cmd.run = base_bcd;
        cmd.eol = in_data.last_of_line;
        cmd.eop = in_data.last_of_page;
        cmd.esc = in_data.pixel &&
                  ((base_bcd[3] != 4'd0) || (base_bcd[2] != 4'd0) ||
                   (base_bcd[1] != 4'd0) || (base_bcd[0] > thr_eff));
        if (base_bcd[3] != 4'd0)
        begin
            cmd.top_digit = 2'd3;
        end
        else if (base_bcd[2] != 4'd0)
        begin
            cmd.top_digit = 2'd2;
        end
        else if (base_bcd[1] != 4'd0)
        begin
            cmd.top_digit = 2'd1;
        end
        else
        begin
            cmd.top_digit = 2'd0;
        end
    end

    // a clear pixel inside a line only counts
    assign push = accept && (in_data.first_of_page || in_data.pixel || eol_any);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_bin_reg <= '0;
            run_bcd_reg <= '0;
        end
        else if (accept)
        begin
            run_bin_reg <= run_bin_next;
            run_bcd_reg <= run_bcd_next;
        end
    end

endmodule

// ===== hdl/bmte_queue.sv =====
// two-entry request queue between front end and sequencer
module bmte_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  bmte_pkg::cmd_t   push_data,
    input  logic             pop,
    output logic             full,
    output logic             empty,
    output bmte_pkg::cmd_t   head
);
    import bmte_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                               : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                               : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/bmte_back.sv =====
// character sequencer: expands the head request into output characters
module bmte_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             empty,
    input  bmte_pkg::cmd_t   head,
    input  logic [7:0]       mark,
    input  logic             out_stall,
    output logic             pop,
    output logic             out_valid,
    output bmte_pkg::out_t   out_data
);
    import bmte_pkg::*;

    typedef enum logic [8:0] {
        P_IDLE    = 9'b000000001,
        P_HDR     = 9'b000000010,
        P_ESC_PRE = 9'b000000100,
        P_DIG     = 9'b000001000,
        P_ESC_C   = 9'b000010000,
        P_SPACE   = 9'b000100000,
        P_MARK    = 9'b001000000,
        P_HOME    = 9'b010000000,
        P_NL      = 9'b100000000
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [2:0] cnt_reg, cnt_next;
    phase_t     cur_ph;
    logic [2:0] cur_cnt;
    phase_t     end_ph, run_ph, start_ph;
    logic [2:0] run_cnt;
    logic       out_valid_reg;
    out_t       out_reg;
    logic [7:0] ch;
    logic       advance;
    logic       last;

    // section entry points for the head request
    always_comb
    begin
        if (head.eop)
        begin
            end_ph = P_HOME;
        end
        else if (head.eol)
        begin
            end_ph = P_NL;
        end
        else
        begin
            end_ph = P_IDLE;
        end

        run_cnt = 3'd0;
        if (head.esc)
        begin
            run_ph = P_ESC_PRE;
        end
        else if (head.run[0] != 4'd0)
        begin
            run_ph  = P_SPACE;
            run_cnt = head.run[0][2:0];
        end
        else
        begin
            run_ph = P_MARK;
        end

        if (head.hdr)
        begin
            start_ph = P_HDR;
        end
        else if (head.px)
        begin
            start_ph = run_ph;
        end
        else
        begin
            start_ph = end_ph;
        end
    end

    assign cur_ph  = (phase_reg == P_IDLE) ? start_ph : phase_reg;
    assign cur_cnt = (phase_reg == P_IDLE) ? ((start_ph == P_SPACE) ? run_cnt : 3'd0)
                                           : cnt_reg;

    always_comb
    begin
        ch         = CH_ESC;
        phase_next = P_IDLE;
        cnt_next   = 3'd0;
        case (cur_ph)
            P_HDR:
            begin
                case (cur_cnt)
                    3'd1, 3'd4: ch = CH_LBR;
                    3'd2:       ch = CH_H;
                    3'd5:       ch = CH_J;
                    default:    ch = CH_ESC;
                endcase
                if (cur_cnt == 3'd5)
                begin
                    phase_next = head.px ? run_ph : end_ph;
                    cnt_next   = head.px ? run_cnt : 3'd0;
                end
                else
                begin
                    phase_next = P_HDR;
                    cnt_next   = cur_cnt + 3'd1;
                end
            end
            P_ESC_PRE:
            begin
                ch = (cur_cnt == 3'd0) ? CH_ESC : CH_LBR;
                if (cur_cnt == 3'd0)
                begin
                    phase_next = P_ESC_PRE;
                    cnt_next   = 3'd1;
                end
                else
                begin
                    phase_next = P_DIG;
                    cnt_next   = {1'b0, head.top_digit};
                end
            end
            P_DIG:
            begin
                ch = CH_ZERO + {4'd0, head.run[cur_cnt[1:0]]};
                if (cur_cnt == 3'd0)
                begin
                    phase_next = P_ESC_C;
                end
                else
                begin
                    phase_next = P_DIG;
                    cnt_next   = cur_cnt - 3'd1;
                end
            end
            P_ESC_C:
            begin
                ch         = CH_C;
                phase_next = P_MARK;
            end
            P_SPACE:
            begin
                ch = CH_SPACE;
                if (cur_cnt == 3'd1)
                begin
                    phase_next = P_MARK;
                end
                else
                begin
                    phase_next = P_SPACE;
                    cnt_next   = cur_cnt - 3'd1;
                end
            end
            P_MARK:
            begin
                ch         = mark;
                phase_next = end_ph;
            end
            P_HOME:
            begin
                case (cur_cnt)
                    3'd1:    ch = CH_LBR;
                    3'd2:    ch = CH_H;
                    default: ch = CH_ESC;
                endcase
                if (cur_cnt != 3'd2)
                begin
                    phase_next = P_HOME;
                    cnt_next   = cur_cnt + 3'd1;
                end
            end
            P_NL:
            begin
                ch = CH_NL;
            end
            default:
            begin
                ch = CH_ESC;
            end
        endcase
    end

    assign advance = !empty && (!out_valid_reg || !out_stall);
    assign last    = (phase_next == P_IDLE);
    assign pop     = advance && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= P_IDLE;
            cnt_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg     <= phase_next;
                cnt_reg       <= cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg.char_code   <= ch;
            out_reg.last_of_run <= last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // a request stays at the queue head until its last character
    a_busy_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != P_IDLE |-> !empty)
        else $error("sequencer busy with an empty queue");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == P_DIG |-> cnt_reg[2] == 1'b0)
        else $error("digit index out of range");

    a_space_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == P_SPACE |-> cnt_reg != 3'd0)
        else $error("space phase with zero spaces left");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> phase_reg == $past(phase_reg))
        else $error("sequencer moved while output stalled");

endmodule

// ===== hdl/bitmap_to_ansi_text_encoder.sv =====
// top level of the bitmap to ansi text encoder
// One pixel per request in, one terminal character per cycle out while out_stall is low. The
// front end takes a pixel every cycle while its two-entry queue has room; pixels that cause
// no output (clear pixels inside a line) only update the blank-run counter. The sequencer
// then expands each queued request into 1 to 11 characters, e.g. 1 for a newline, run
// length plus 1 for a short run and its mark, digits plus 4 for a cursor-forward run, plus 6
// for a page header and 3 for a page-end home. The output character channel sets the
// sustained rate. Registers: index 0 escape threshold (4 bits, reset 5, above 7 acts as 7),
// index 1 mark character (8 bits, reset 42); write them only while the block is idle.
module bitmap_to_ansi_text_encoder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  bmte_pkg::in_t                       in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output bmte_pkg::out_t                      out_data,
    input  logic                                cfg_we,
    input  logic [bmte_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bmte_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import bmte_pkg::*;

    logic [3:0] thr_reg;
    logic [7:0] mark_reg;
    logic       push;
    logic       pop;
    logic       queue_full;
    logic       queue_empty;
    cmd_t       push_cmd;
    cmd_t       head_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THRESH_RESET;
            mark_reg <= MARK_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_THRESH: thr_reg  <= cfg_data[3:0];
                CFG_MARK:   mark_reg <= cfg_data[7:0];
                default:    ;
            endcase
        end
    end

    bmte_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_data    (in_data),
        .queue_full (queue_full),
        .thr        (thr_reg),
        .in_stall   (in_stall),
        .push       (push),
        .cmd        (push_cmd)
    );

    bmte_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .pop       (pop),
        .full      (queue_full),
        .empty     (queue_empty),
        .head      (head_cmd)
    );

    bmte_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (queue_empty),
        .head      (head_cmd),
        .mark      (mark_reg),
        .out_stall (out_stall),
        .pop       (pop),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

// ===== tb/sv/tb.sv =====
// testbench for the bitmap to ansi text encoder
`timescale 1ns / 100ps

module tb;
    import bmte_pkg::*;

    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 30;
    localparam int HOLD_CYCLES   = 400;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    in_t                    in_data = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_t                   out_data;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // predictor state
    logic [RUN_W-1:0] clear_count = '0;
    logic [3:0]       esc_limit = THRESH_RESET;
    logic [7:0]       mark_byte = MARK_RESET;
    out_t             expected_chars[$];

    int fail_count = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    bit gapless = 1'b0;

    // receiver pattern
    int hold_requests = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int mode_left = 0;
    int stall_pct = 0;

    bitmap_to_ansi_text_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic in_t pix_item(bit px, bit first, bit eol, bit eop);
        in_t p;
        p.pixel         = px;
        p.first_of_page = first;
        p.last_of_line  = eol;
        p.last_of_page  = eop;
        return p;
    endfunction

    // works out the characters one request produces and queues them
    function automatic void encode_pixel(in_t p);
        logic [7:0]  seq[$];
        logic [3:0]  lim;
        int unsigned div;
        int unsigned dg;
        bit          lead;
        out_t        e;
        lim = (esc_limit > THRESH_CAP) ? THRESH_CAP : esc_limit;
        if (p.first_of_page)
        begin
            clear_count = '0;
            seq.push_back(CH_ESC);
            seq.push_back(CH_LBR);
            seq.push_back(CH_H);
            seq.push_back(CH_ESC);
            seq.push_back(CH_LBR);
            seq.push_back(CH_J);
        end
        if (p.pixel)
        begin
            if (clear_count > lim)
            begin
                seq.push_back(CH_ESC);
                seq.push_back(CH_LBR);
                div  = 1000;
                lead = 1'b0;
                while (div != 0)
                begin
                    dg = (clear_count / div) % 10;
                    if (dg != 0 || lead || div == 1)
                    begin
                        seq.push_back(CH_ZERO + 8'(dg));
                        lead = 1'b1;
                    end
                    div = div / 10;
                end
                seq.push_back(CH_C);
            end
            else
            begin
                for (int i = 0; i < clear_count; i++)
                    seq.push_back(CH_SPACE);
            end
            clear_count = '0;
            seq.push_back(mark_byte);
        end
        else if (clear_count < MAX_LINE_PIXELS)
        begin
            clear_count = clear_count + 1'b1;
        end
        if (p.last_of_line || p.last_of_page)
        begin
            clear_count = '0;
            if (p.last_of_page)
            begin
                seq.push_back(CH_ESC);
                seq.push_back(CH_LBR);
                seq.push_back(CH_H);
            end
            else
            begin
                seq.push_back(CH_NL);
            end
        end
        foreach (seq[i])
        begin
            e.char_code   = seq[i];
            e.last_of_run = (i == seq.size() - 1);
            expected_chars.push_back(e);
        end
    endfunction

    task automatic report_mismatch(input string msg);
        if (fail_count < 50)
            $display("%0t: %s", $time, msg);
        fail_count++;
    endtask

    // sender: holds the request until taken, then predicts
    task automatic send_pixel(input in_t p);
        in_valid <= 1'b1;
        in_data  <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        encode_pixel(p);
    endtask

    // bursts of random length with random gaps between them
    task automatic pace();
        if (gapless)
            return;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(24, 1);
            in_valid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge clk);
        end
    endtask

    task automatic send_run(input int clears, input in_t tail);
        for (int i = 0; i < clears; i++)
        begin
            send_pixel(pix_item(1'b0, 1'b0, 1'b0, 1'b0));
            pace();
        end
        send_pixel(tail);
        pace();
    endtask

    // clear pixels give no output, so allow the block to finish them too
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_THRESH)
            esc_limit = val[3:0];
        else
            mark_byte = val;
        @(posedge clk);
    endtask

    task automatic send_page(inout int sent);
        int  lines;
        int  width;
        int  density;
        bit  broken;
        in_t p;
        lines  = $urandom_range(4, 1);
        broken = ($urandom_range(9) == 0);
        for (int ln = 0; ln < lines; ln++)
        begin
            width   = ($urandom_range(7) == 0) ? $urandom_range(60, 17) : $urandom_range(16, 1);
            density = $urandom_range(90, 5);
            for (int x = 0; x < width; x++)
            begin
                p.pixel         = ($urandom_range(99) < density);
                p.first_of_page = (ln == 0 && x == 0);
                p.last_of_line  = (x == width - 1);
                p.last_of_page  = (ln == lines - 1 && x == width - 1);
                // broken pages may drop the line flag at page end and may drop the page start flag
                if (broken && p.last_of_page)
                    p.last_of_line = 1'($urandom_range(1));
                if (broken && p.first_of_page)
                    p.first_of_page = 1'($urandom_range(1));
                send_pixel(p);
                pace();
                sent++;
            end
        end
    endtask

    task automatic test_page_basics();
        send_run(0, pix_item(1'b1, 1'b1, 1'b0, 1'b0));
        send_run(3, pix_item(1'b1, 1'b0, 1'b0, 1'b0));
        send_run(5, pix_item(1'b1, 1'b0, 1'b0, 1'b0));
        send_run(6, pix_item(1'b1, 1'b0, 1'b0, 1'b0));
        send_run(2, pix_item(1'b0, 1'b0, 1'b1, 1'b0));
        send_run(2, pix_item(1'b1, 1'b0, 1'b1, 1'b0));
        // page start clears the run before counting its own clear pixel
        send_run(3, pix_item(1'b0, 1'b1, 1'b0, 1'b0));
        send_run(0, pix_item(1'b1, 1'b0, 1'b0, 1'b0));
        // page end without line end
        send_run(1, pix_item(1'b0, 1'b0, 1'b0, 1'b1));
        send_run(0, pix_item(1'b1, 1'b1, 1'b1, 1'b1));
        drain();
    endtask

    task automatic test_threshold_limits();
        write_reg(CFG_THRESH, 8'd0);
        send_run(0, pix_item(1'b1, 1'b1, 1'b0, 1'b0));
        send_run(0, pix_item(1'b1, 1'b0, 1'b0, 1'b0));
        send_run(1, pix_item(1'b1, 1'b0, 1'b1, 1'b0));
        drain();
        // above seven acts as seven
        write_reg(CFG_THRESH, 8'hFF);
        send_run(7, pix_item(1'b1, 1'b0, 1'b0, 1'b0));
        send_run(8, pix_item(1'b1, 1'b0, 1'b1, 1'b0));
        drain();
        write_reg(CFG_THRESH, 8'd8);
        send_run(8, pix_item(1'b1, 1'b0, 1'b0, 1'b1));
        drain();
    endtask

    task automatic test_mark_codes();
        write_reg(CFG_MARK, 8'd0);
        send_run(0, pix_item(1'b1, 1'b1, 1'b0, 1'b0));
        drain();
        write_reg(CFG_MARK, 8'hFF);
        send_run(2, pix_item(1'b1, 1'b0, 1'b0, 1'b1));
        drain();
    endtask

    task automatic test_long_runs();
        write_reg(CFG_THRESH, {4'hA, THRESH_RESET});
        write_reg(CFG_MARK, MARK_RESET);
        send_run(10, pix_item(1'b1, 1'b1, 1'b0, 1'b0));
        // three-digit cursor-forward run
        send_run(120, pix_item(1'b1, 1'b0, 1'b0, 1'b0));
        send_run(9, pix_item(1'b1, 1'b0, 1'b0, 1'b1));
        drain();
    endtask

    task automatic test_random_pages();
        int sent;
        int n;
        for (int phase = 0; phase < 6; phase++)
        begin
            drain();
            case (phase)
                0: begin write_reg(CFG_THRESH, 8'd0); write_reg(CFG_MARK, 8'hFF); end
                1: begin write_reg(CFG_THRESH, 8'd15); write_reg(CFG_MARK, 8'd0); end
                default:
                begin
                    write_reg(CFG_THRESH, 8'($urandom));
                    write_reg(CFG_MARK, 8'($urandom));
                end
            endcase
            gapless = (phase == 3);
            sent = 0;
            while (sent < 16)
            begin
                if ($urandom_range(9) < 2)
                begin
                    n = $urandom_range(6, 1);
                    repeat (n)
                    begin
                        send_pixel(in_t'(4'($urandom_range(15))));
                        pace();
                        sent++;
                    end
                end
                else
                begin
                    send_page(sent);
                end
            end
        end
        gapless = 1'b0;
        drain();
    endtask

    // receiver holds off while the sender keeps offering requests
    task automatic test_output_hold();
        write_reg(CFG_THRESH, 8'd2);
        gapless = 1'b1;
        hold_requests <= hold_requests + 1;
        for (int i = 0; i < 80; i++)
        begin
            send_pixel(pix_item(1'($urandom_range(1)), i == 0, i % 8 == 7, i == 79));
            pace();
        end
        gapless = 1'b0;
        drain();
    endtask

    always @(posedge clk)
    begin
        if (hold_seen != hold_requests)
        begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                mode_left <= $urandom_range(400, 40);
                case ($urandom_range(3))
                    0: stall_pct <= 0;
                    1: stall_pct <= 15;
                    2: stall_pct <= 50;
                    default: stall_pct <= 85;
                endcase
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_chars.size() == 0)
            begin
                report_mismatch($sformatf("unexpected char %0d", out_data.char_code));
            end
            else
            begin
                want = expected_chars.pop_front();
                if (out_data.char_code !== want.char_code)
                    report_mismatch($sformatf("char_code got %0d want %0d",
                                              out_data.char_code, want.char_code));
                if (out_data.last_of_run !== want.last_of_run)
                    report_mismatch($sformatf("last_of_run got %0b want %0b",
                                              out_data.last_of_run, want.last_of_run));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_page_basics();
        test_threshold_limits();
        test_mark_codes();
        test_long_runs();
        test_random_pages();
        test_output_hold();
        drain();
        if (fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/bmte_pkg.sv
hdl/bmte_front.sv
hdl/bmte_queue.sv
hdl/bmte_back.sv
hdl/bitmap_to_ansi_text_encoder.sv
tb/sv/tb.sv
